// File: rtl/tha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP handshake responder package
// Shared widths, codes, defaults and record types of the responder.
// ----------------------------------------------------------------------------
package tha_pkg;

	// Default table depth and register reset value.
	localparam int CONN_ENTRIES_DEF = 64;
	localparam logic [15:0] LISTEN_PORT_RST = 16'd4000;

	// Header values that are handled.
	localparam logic [3:0] IP_VER_V4 = 4'd4;
	localparam logic [7:0] IP_PROTO_TCP = 8'd6;

	// Result kinds, carried on the output tuser.
	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_OUT_OF_SEQ = 2'd1;
	localparam logic [1:0] KIND_TABLE_FULL = 2'd2;

	// Stream widths; the tdata widths are padded to whole bytes.
	localparam int IN_TDATA_W = 224;
	localparam int OUT_TDATA_W = 168;
	localparam int OUT_TUSER_W = 2;

	// One parsed header.
	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [3:0] ip_version;
		logic [7:0] ip_protocol;
		logic syn_flag;
		logic ack_flag;
		logic [31:0] seq_num;
		logic [31:0] ack_num;
		logic [15:0] payload_len;
		logic [31:0] fresh_isn;
	} item_t;

	// One result transfer.
	typedef struct packed {
		logic [1:0] kind;
		logic reply_syn;
		logic reply_ack;
		logic [31:0] reply_seq;
		logic [31:0] reply_ack_num;
		logic [31:0] peer_addr;
		logic [31:0] local_addr;
		logic [15:0] peer_port;
		logic [15:0] local_port;
		logic last;
	} out_t;

	// Per-item result record before the addresses are attached.
	typedef struct packed {
		logic [1:0] kind;
		logic syn;
		logic ack;
		logic [31:0] seq;
		logic [31:0] acknum;
	} rec_t;

	// One connection table entry.
	typedef struct packed {
		logic [31:0] peer_addr;
		logic [31:0] local_addr;
		logic [31:0] port_pair;
		logic [31:0] initial_seq;
		logic [31:0] initial_peer_seq;
		logic [31:0] expected_seq;
		logic established;
	} entry_t;

endpackage

// File: rtl/tha_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/tha_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared adder
// 32-bit adder with carry in and carry out, used for sums and compares.
// ----------------------------------------------------------------------------
module tha_alu (
	input logic [31:0] a,
	input logic [31:0] b,
	input logic cin,
	output logic [32:0] sum
);

	// A compare is a + ~b + 1; the carry out is set when a >= b.
	assign sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};

endmodule

// File: rtl/tha_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Responder sequencer
// Filters a header, scans the connection table, steps the shared adder
// through the sequence arithmetic, writes the entry back and emits results.
// ----------------------------------------------------------------------------
module tha_ctrl
	import tha_pkg::*;
#(
	parameter int CONN_ENTRIES = CONN_ENTRIES_DEF,
	localparam int IDX_W = (CONN_ENTRIES > 1) ? $clog2(CONN_ENTRIES) : 1,
	localparam int CNT_W = $clog2(CONN_ENTRIES + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic [15:0] listen_port,
	input logic item_valid,
	output logic item_ready,
	input item_t item,
	output logic res_valid,
	input logic res_ready,
	output out_t res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_SYN = 3'd3;
	localparam logic [2:0] ST_CMP = 3'd4;
	localparam logic [2:0] ST_ADD = 3'd5;
	localparam logic [2:0] ST_WRITE = 3'd6;
	localparam logic [2:0] ST_EMIT = 3'd7;

	logic [2:0] state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] scan_q;
	logic issued_q;
	logic [IDX_W-1:0] cmp_idx_q;
	logic [IDX_W-1:0] slot_q;
	logic hit_q;
	logic eq_q;
	item_t item_q;
	logic [31:0] init_seq_q;
	logic [31:0] init_peer_q;
	logic [31:0] exp_q;
	logic est_q;
	rec_t rec_q [2];
	logic [1:0] nres_q;
	logic eidx_q;

	logic [31:0] alu_a;
	logic [31:0] alu_b;
	logic alu_cin;
	logic [32:0] alu_sum;
	logic issue;
	logic match;
	logic table_full;
	logic emit_last;
	logic ram_we;
	entry_t ram_wdata;
	entry_t ram_rdata;
	rec_t rec_cur;

	// Connection table.
	tha_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CONN_ENTRIES)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(slot_q),
		.wdata(ram_wdata),
		.re(issue),
		.raddr(scan_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// Shared adder.
	tha_alu u_alu (
		.a(alu_a),
		.b(alu_b),
		.cin(alu_cin),
		.sum(alu_sum)
	);

	// Operand selection for the shared adder in each step.
	always_comb begin
		alu_a = init_peer_q;
		alu_b = 32'd0;
		alu_cin = 1'b1;
		case (state_q)
			ST_CMP: begin
				alu_a = exp_q;
				alu_b = ~item_q.seq_num;
				alu_cin = 1'b1;
			end
			ST_ADD: begin
				alu_a = item_q.seq_num;
				alu_b = {16'd0, item_q.payload_len};
				alu_cin = 1'b0;
			end
			default: begin
				alu_a = init_peer_q;
				alu_b = 32'd0;
				alu_cin = 1'b1;
			end
		endcase
	end

	// Table scan and tuple compare.
	assign issue = (state_q == ST_SCAN) && (scan_q < cnt_q);
	assign match = issued_q
		&& (ram_rdata.peer_addr == item_q.src_addr)
		&& (ram_rdata.local_addr == item_q.dst_addr)
		&& (ram_rdata.port_pair == {item_q.src_port, item_q.dst_port});
	assign table_full = (cnt_q == CNT_W'(CONN_ENTRIES));

	// Entry write-back.
	assign ram_we = (state_q == ST_WRITE);
	always_comb begin
		ram_wdata.peer_addr = item_q.src_addr;
		ram_wdata.local_addr = item_q.dst_addr;
		ram_wdata.port_pair = {item_q.src_port, item_q.dst_port};
		ram_wdata.initial_seq = init_seq_q;
		ram_wdata.initial_peer_seq = init_peer_q;
		ram_wdata.expected_seq = exp_q;
		ram_wdata.established = est_q;
	end

	// Result presentation.
	assign item_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_EMIT);
	assign rec_cur = rec_q[eidx_q];
	assign emit_last = (({1'b0, eidx_q} + 2'd1) == nres_q);
	always_comb begin
		res.kind = rec_cur.kind;
		res.reply_syn = rec_cur.syn;
		res.reply_ack = rec_cur.ack;
		res.reply_seq = rec_cur.seq;
		res.reply_ack_num = rec_cur.acknum;
		res.peer_addr = item_q.src_addr;
		res.local_addr = item_q.dst_addr;
		res.peer_port = item_q.src_port;
		res.local_port = item_q.dst_port;
		res.last = emit_last;
	end

	// Control state: sequencer, fill count and scan flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			issued_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					issued_q <= 1'b0;
					if (item_q.ip_version != IP_VER_V4 || item_q.ip_protocol != IP_PROTO_TCP
						|| item_q.dst_port != listen_port) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					issued_q <= issue;
					if (match) begin
						state_q <= ST_SYN;
					end else if (!issued_q && !issue) begin
						if (!item_q.syn_flag) begin
							state_q <= ST_IDLE;
						end else if (table_full) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_SYN;
						end
					end
				end
				ST_SYN: begin
					state_q <= item_q.ack_flag ? ST_CMP : ST_WRITE;
				end
				ST_CMP: begin
					if (!alu_sum[32]) begin
						state_q <= ST_EMIT;
					end else if (item_q.payload_len == 16'd0) begin
						state_q <= ST_WRITE;
					end else begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (!hit_q) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					state_q <= (nres_q != 2'd0) ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (res_ready && emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_q <= item;
				end
			end
			ST_CHECK: begin
				scan_q <= '0;
				eidx_q <= 1'b0;
				nres_q <= 2'd0;
			end
			ST_SCAN: begin
				if (issue) begin
					scan_q <= scan_q + CNT_W'(1);
					cmp_idx_q <= scan_q[IDX_W-1:0];
				end
				if (match) begin
					hit_q <= 1'b1;
					slot_q <= cmp_idx_q;
					init_seq_q <= ram_rdata.initial_seq;
					init_peer_q <= ram_rdata.initial_peer_seq;
					exp_q <= ram_rdata.expected_seq;
					est_q <= ram_rdata.established;
				end else if (!issued_q && !issue) begin
					hit_q <= 1'b0;
					slot_q <= cnt_q[IDX_W-1:0];
					init_seq_q <= item_q.fresh_isn;
					init_peer_q <= item_q.seq_num;
					exp_q <= item_q.seq_num;
					est_q <= 1'b0;
					if (table_full) begin
						rec_q[0] <= '{kind: KIND_TABLE_FULL, syn: 1'b0, ack: 1'b0,
							seq: 32'd0, acknum: 32'd0};
						nres_q <= 2'd1;
					end
				end
			end
			ST_SYN: begin
				// SYN-ACK carries the initial peer sequence plus one.
				if (item_q.syn_flag) begin
					rec_q[0] <= '{kind: KIND_REPLY, syn: 1'b1, ack: 1'b1,
						seq: init_seq_q, acknum: alu_sum[31:0]};
					nres_q <= 2'd1;
				end
				// The first ACK fixes the expected sequence.
				if (item_q.ack_flag && !est_q) begin
					exp_q <= item_q.seq_num;
					est_q <= 1'b1;
				end
			end
			ST_CMP: begin
				eq_q <= (alu_sum[31:0] == 32'd0);
				if (!alu_sum[32]) begin
					rec_q[nres_q[0]] <= '{kind: KIND_OUT_OF_SEQ, syn: 1'b0, ack: 1'b0,
						seq: 32'd0, acknum: 32'd0};
					nres_q <= nres_q + 2'd1;
				end
			end
			ST_ADD: begin
				rec_q[nres_q[0]] <= '{kind: KIND_REPLY, syn: 1'b0, ack: 1'b1,
					seq: item_q.ack_num, acknum: alu_sum[31:0]};
				nres_q <= nres_q + 2'd1;
				if (eq_q) begin
					exp_q <= alu_sum[31:0];
				end
			end
			ST_EMIT: begin
				if (res_ready) begin
					eidx_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/tcp_handshake_ack_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP handshake and ACK responder
// Answers SYN and data-carrying ACK segments of a listen port from a
// connection table, and flags out-of-sequence segments and a full table.
// ----------------------------------------------------------------------------
// Search: the tuple search reads one entry a cycle from the single read port of the
// table RAM, over the filled entries (up to CONN_ENTRIES), and stops at a match.
// Flow: one item at a time; results wait in the output register.
// Reset: the table is empty, listen_port is 4000 and no result is valid.
module tcp_handshake_ack_responder
	import tha_pkg::*;
#(
	parameter int CONN_ENTRIES = CONN_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	// Configuration write: listen_port.
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [15:0] cfg_data,
	// Input headers.
	input logic s_tvalid,
	output logic s_tready,
	// tdata from bit 0: src_addr, dst_addr, src_port, dst_port, ip_version,
	// ip_protocol, syn_flag, ack_flag, seq_num, ack_num, payload_len, fresh_isn.
	input logic [IN_TDATA_W-1:0] s_tdata,
	// Results.
	output logic m_tvalid,
	input logic m_tready,
	// tdata from bit 0: reply_syn, reply_ack, reply_seq, reply_ack_num,
	// peer_addr, local_addr, peer_port, local_port.
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// tuser: kind.
	output logic [OUT_TUSER_W-1:0] m_tuser,
	output logic m_tlast
);

	logic [15:0] listen_port_q;
	item_t item;
	out_t res;
	logic res_valid;
	logic res_ready;
	out_t out_q;
	logic out_valid_q;

	// Listen port register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_port_q <= LISTEN_PORT_RST;
		end else if (cfg_valid) begin
			listen_port_q <= cfg_data;
		end
	end

	// Input field unpacking.
	always_comb begin
		item.src_addr = s_tdata[31:0];
		item.dst_addr = s_tdata[63:32];
		item.src_port = s_tdata[79:64];
		item.dst_port = s_tdata[95:80];
		item.ip_version = s_tdata[99:96];
		item.ip_protocol = s_tdata[107:100];
		item.syn_flag = s_tdata[108];
		item.ack_flag = s_tdata[109];
		item.seq_num = s_tdata[141:110];
		item.ack_num = s_tdata[173:142];
		item.payload_len = s_tdata[189:174];
		item.fresh_isn = s_tdata[221:190];
	end

	tha_ctrl #(
		.CONN_ENTRIES(CONN_ENTRIES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.listen_port(listen_port_q),
		.item_valid(s_tvalid),
		.item_ready(s_tready),
		.item(item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// Output register; it takes a new result when empty or being drained.
	assign res_ready = !out_valid_q || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	// Output field packing.
	assign m_tvalid = out_valid_q;
	assign m_tuser = out_q.kind;
	assign m_tlast = out_q.last;
	assign m_tdata = {6'd0, out_q.local_port, out_q.peer_port, out_q.local_addr,
		out_q.peer_addr, out_q.reply_ack_num, out_q.reply_seq, out_q.reply_ack,
		out_q.reply_syn};

endmodule

// File: rtl/tha_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Responder port checker
// Watches the stream ports of the responder for rule breaks over time.
// ----------------------------------------------------------------------------
module tha_checker
	import tha_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [OUT_TUSER_W-1:0] m_tuser,
	input logic m_tlast
);

	// A stalled result transfer holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// The block is busy in the cycle after it takes a header.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("header taken in consecutive cycles");

	// Error results always end the results of their header.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_OUT_OF_SEQ || m_tuser == KIND_TABLE_FULL) |-> m_tlast)
		else $error("error result not last");

	// Every reply segment carries ACK; error results do not.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == KIND_REPLY) == m_tdata[1])
		else $error("reply ACK bit inconsistent with kind");

endmodule

bind tcp_handshake_ack_responder tha_checker u_tha_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser),
	.m_tlast(m_tlast)
);
